// ----- rtl/birt_pkg.sv -----
// Shared types and constants of the bidirectional index remap table.
package birt_pkg;

    localparam int IDX_W = 10;
    localparam int TSZ_W = 11;
    localparam logic [TSZ_W-1:0] TSZ_RESET = 11'd1024;

    localparam int CMDQ_DEPTH = 2;
    localparam int RESQ_DEPTH = 2;

    localparam logic [2:0] REQ_CUR_FROM_OLD = 3'd0;
    localparam logic [2:0] REQ_OLD_FROM_CUR = 3'd1;
    localparam logic [2:0] REQ_REMOVE       = 3'd2;
    localparam logic [2:0] REQ_MOVE_PAIR    = 3'd3;
    localparam logic [2:0] REQ_REMOVAL      = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_Q_O2C,
        OP_Q_C2O,
        OP_REMOVE,
        OP_RMENTRY,
        OP_MOVE
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic             bv;
        logic             stage;
        logic             apply;
        logic [1:0]       status;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             valid;
        logic [1:0]       status;
    } t_res;

    typedef enum logic [3:0] {
        B_INIT,
        B_IDLE,
        B_QRESP,
        B_RMWR,
        B_A1_RS,
        B_A1_RC,
        B_A1_WT,
        B_A2_RS,
        B_A2_WR
    } t_bstate;

endpackage

// ----- rtl/birt_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module birt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/birt_fifo.sv -----
// Small register queue used between the front, the back and the result port.
module birt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wptr + 1'b1);
        end
        if (w_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rptr + 1'b1);
        end
        if (w_push && !w_pop) begin
            n_cnt = CW'(r_cnt + 1'b1);
        end else if (w_pop && !w_push) begin
            n_cnt = CW'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule

// ----- rtl/birt_front.sv -----
// Front end: takes requests, checks ranges and buffer space, and issues commands.
module birt_front #(
    parameter int TABLE_DEPTH = 1024,
    parameter int STAGE_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [birt_pkg::TSZ_W-1:0]     i_cfg_data,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [2:0]                     i_req_type,
    input  logic [birt_pkg::IDX_W-1:0]     i_index_a,
    input  logic [birt_pkg::IDX_W-1:0]     i_index_b,
    input  logic                           i_b_valid,
    input  logic                           i_last_of_batch,
    input  logic                           i_init_done,
    input  logic                           i_cmd_full,
    output logic                           o_cmd_push,
    output birt_pkg::t_cmd                 o_cmd
);
    import birt_pkg::*;

    localparam int CW = $clog2(STAGE_DEPTH + 1);

    logic [TSZ_W-1:0] r_ts;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_acc, w_a_ok, w_b_ok, w_stage_full;

    // An index is in range below both the programmed size and the table depth.
    assign w_a_ok = (TSZ_W'(i_index_a) < r_ts) && (32'(i_index_a) < 32'(TABLE_DEPTH));
    assign w_b_ok = (TSZ_W'(i_index_b) < r_ts) && (32'(i_index_b) < 32'(TABLE_DEPTH));
    assign w_stage_full = (r_cnt == CW'(STAGE_DEPTH));

    assign o_full     = !i_init_done || i_cmd_full;
    assign w_acc      = i_push && !o_full;
    assign o_cmd_push = w_acc;

    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = OP_NONE;
        o_cmd.a      = i_index_a;
        o_cmd.b      = i_b_valid ? i_index_b : '0;
        o_cmd.bv     = i_b_valid;
        o_cmd.status = ST_OK;
        unique case (i_req_type) inside
            REQ_CUR_FROM_OLD, REQ_OLD_FROM_CUR: begin
                if (!w_a_ok) begin
                    o_cmd.status = ST_RANGE;
                end else begin
                    o_cmd.op = (i_req_type == REQ_CUR_FROM_OLD) ? OP_Q_O2C : OP_Q_C2O;
                end
            end
            REQ_REMOVE: begin
                if (!w_a_ok) begin
                    o_cmd.status = ST_RANGE;
                end else begin
                    o_cmd.op = OP_REMOVE;
                end
            end
            REQ_REMOVAL: begin
                if (!w_a_ok) begin
                    o_cmd.status = ST_RANGE;
                end else begin
                    o_cmd.op = OP_RMENTRY;
                end
            end
            REQ_MOVE_PAIR: begin
                o_cmd.op    = OP_MOVE;
                o_cmd.apply = i_last_of_batch;
                if (!w_a_ok || (i_b_valid && !w_b_ok)) begin
                    o_cmd.status = ST_RANGE;
                end else if (w_stage_full) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.stage = 1'b1;
                end
            end
            default: begin
                o_cmd.op = OP_NONE;
            end
        endcase
    end

    // Mirrors the staging count kept by the back end, in transaction order.
    always_comb begin
        n_cnt = r_cnt;
        if (w_acc && (o_cmd.op == OP_MOVE)) begin
            if (o_cmd.apply) begin
                n_cnt = '0;
            end else if (o_cmd.stage) begin
                n_cnt = CW'(r_cnt + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts  <= TSZ_RESET;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cfg_we) begin
                r_ts <= i_cfg_data;
            end
        end
    end
endmodule

// ----- rtl/birt_back.sv -----
// Back end: owns both remap tables and the staging buffer, and carries out commands.
module birt_back #(
    parameter int TABLE_DEPTH = 1024,
    parameter int STAGE_DEPTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  birt_pkg::t_cmd  i_cmd,
    input  logic            i_cmd_empty,
    output logic            o_cmd_pop,
    input  logic            i_res_full,
    output logic            o_res_push,
    output birt_pkg::t_res  o_res,
    output logic            o_init_done
);
    import birt_pkg::*;

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int SAW = (STAGE_DEPTH > 1) ? $clog2(STAGE_DEPTH) : 1;
    localparam int CW  = $clog2(STAGE_DEPTH + 1);

    typedef struct packed {
        logic          ok;
        logic [AW-1:0] idx;
    } t_tent;

    typedef struct packed {
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] nxt;
        logic             nok;
        logic             old_ok;
        logic [AW-1:0]    old;
    } t_stent;

    t_bstate r_state, n_state;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_i, n_i;
    t_cmd          r_cmd, n_cmd;
    t_stent        r_ent, n_ent;

    logic          o2c_we, c2o_we, st_we;
    logic [AW-1:0] o2c_waddr, o2c_raddr, c2o_waddr, c2o_raddr;
    t_tent         o2c_wdata, o2c_rdata, c2o_wdata, c2o_rdata, w_qent;
    logic [SAW-1:0] st_waddr, st_raddr;
    t_stent        st_wdata, st_rdata;

    logic          w_start, w_apply_run, w_last_pair;
    logic [CW-1:0] w_n_apply;

    assign w_start     = (r_state == B_IDLE) && !i_cmd_empty && !i_res_full;
    assign w_n_apply   = CW'(r_cnt + CW'(i_cmd.stage));
    assign w_apply_run = i_cmd.apply && (w_n_apply != '0);
    assign w_last_pair = (CW'(r_i + 1'b1) == r_n);
    assign o_init_done = (r_state != B_INIT);
    assign w_qent      = (r_cmd.op == OP_Q_O2C) ? o2c_rdata : c2o_rdata;

    birt_ram #(.WIDTH($bits(t_tent)), .DEPTH(TABLE_DEPTH)) u_o2c (
        .i_clk  (i_clk),
        .i_we   (o2c_we),
        .i_waddr(o2c_waddr),
        .i_wdata(o2c_wdata),
        .i_raddr(o2c_raddr),
        .o_rdata(o2c_rdata)
    );

    birt_ram #(.WIDTH($bits(t_tent)), .DEPTH(TABLE_DEPTH)) u_c2o (
        .i_clk  (i_clk),
        .i_we   (c2o_we),
        .i_waddr(c2o_waddr),
        .i_wdata(c2o_wdata),
        .i_raddr(c2o_raddr),
        .o_rdata(c2o_rdata)
    );

    birt_ram #(.WIDTH($bits(t_stent)), .DEPTH(STAGE_DEPTH)) u_stage (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(st_wdata),
        .i_raddr(st_raddr),
        .o_rdata(st_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_INIT: begin
                if (r_ptr == AW'(TABLE_DEPTH - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (w_start) begin
                    unique case (i_cmd.op) inside
                        OP_Q_O2C, OP_Q_C2O: n_state = B_QRESP;
                        OP_REMOVE:          n_state = B_RMWR;
                        OP_MOVE:            n_state = w_apply_run ? B_A1_RS : B_IDLE;
                        default:            n_state = B_IDLE;
                    endcase
                end
            end
            B_QRESP: n_state = B_IDLE;
            B_RMWR:  n_state = B_IDLE;
            B_A1_RS: n_state = B_A1_RC;
            B_A1_RC: n_state = B_A1_WT;
            B_A1_WT: n_state = w_last_pair ? B_A2_RS : B_A1_RS;
            B_A2_RS: n_state = B_A2_WR;
            B_A2_WR: n_state = w_last_pair ? B_IDLE : B_A2_RS;
            default: n_state = B_INIT;
        endcase
    end

    // Memory controls, command pop and result push.
    always_comb begin
        o2c_we     = 1'b0;
        c2o_we     = 1'b0;
        st_we      = 1'b0;
        o2c_waddr  = AW'(i_cmd.a);
        c2o_waddr  = AW'(i_cmd.a);
        o2c_wdata  = '0;
        c2o_wdata  = '0;
        o2c_raddr  = AW'(i_cmd.a);
        c2o_raddr  = AW'(i_cmd.a);
        st_waddr   = r_i[SAW-1:0];
        st_wdata   = r_ent;
        st_raddr   = r_i[SAW-1:0];
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        o_res.status = r_cmd.status;
        unique case (r_state)
            B_INIT: begin
                o2c_we    = 1'b1;
                c2o_we    = 1'b1;
                o2c_waddr = r_ptr;
                c2o_waddr = r_ptr;
                o2c_wdata = '{ok: 1'b1, idx: r_ptr};
                c2o_wdata = '{ok: 1'b1, idx: r_ptr};
            end
            B_IDLE: begin
                o_res.status = i_cmd.status;
                if (w_start) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_RMENTRY: begin
                            c2o_we     = 1'b1;
                            o_res_push = 1'b1;
                        end
                        OP_MOVE: begin
                            if (i_cmd.stage) begin
                                st_we    = 1'b1;
                                st_waddr = r_cnt[SAW-1:0];
                                st_wdata = '{cur: i_cmd.a, nxt: i_cmd.b, nok: i_cmd.bv,
                                             old_ok: 1'b0, old: '0};
                            end
                            o_res_push = !w_apply_run;
                        end
                        OP_NONE: o_res_push = 1'b1;
                        default: o_res_push = 1'b0;
                    endcase
                end
            end
            B_QRESP: begin
                o_res_push  = 1'b1;
                o_res.valid = w_qent.ok;
                o_res.idx   = w_qent.ok ? IDX_W'(w_qent.idx) : '0;
            end
            B_RMWR: begin
                // The old index read last cycle loses its forward mapping as well.
                o2c_we     = c2o_rdata.ok;
                o2c_waddr  = c2o_rdata.idx;
                c2o_we     = 1'b1;
                c2o_waddr  = AW'(r_cmd.a);
                o_res_push = 1'b1;
            end
            B_A1_RC: begin
                c2o_raddr = AW'(st_rdata.cur);
            end
            B_A1_WT: begin
                // Snapshot the old index before any table of the batch is written.
                st_we           = 1'b1;
                st_wdata.old_ok = c2o_rdata.ok;
                st_wdata.old    = c2o_rdata.idx;
            end
            B_A2_WR: begin
                o2c_we    = st_rdata.old_ok;
                o2c_waddr = st_rdata.old;
                o2c_wdata = '{ok: st_rdata.nok,
                              idx: st_rdata.nok ? AW'(st_rdata.nxt) : '0};
                c2o_we    = st_rdata.nok;
                c2o_waddr = AW'(st_rdata.nxt);
                c2o_wdata = '{ok: st_rdata.old_ok,
                              idx: st_rdata.old_ok ? st_rdata.old : '0};
                o_res_push = w_last_pair;
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    // Sequencer registers.
    always_comb begin
        n_ptr = r_ptr;
        n_cnt = r_cnt;
        n_n   = r_n;
        n_i   = r_i;
        n_cmd = r_cmd;
        n_ent = r_ent;
        if (r_state == B_INIT) begin
            n_ptr = AW'(r_ptr + 1'b1);
        end
        if (w_start) begin
            n_cmd = i_cmd;
            if (i_cmd.op == OP_MOVE) begin
                if (i_cmd.apply) begin
                    n_cnt = '0;
                    n_n   = w_n_apply;
                    n_i   = '0;
                end else if (i_cmd.stage) begin
                    n_cnt = CW'(r_cnt + 1'b1);
                end
            end
        end
        if (r_state == B_A1_RC) begin
            n_ent = st_rdata;
        end
        if (r_state == B_A1_WT) begin
            n_i = w_last_pair ? '0 : CW'(r_i + 1'b1);
        end
        if (r_state == B_A2_WR) begin
            n_i = CW'(r_i + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_INIT;
            r_ptr   <= '0;
            r_cnt   <= '0;
            r_n     <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
            r_i     <= n_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_ent <= n_ent;
    end
endmodule

// ----- rtl/bidirectional_index_remap_table_core.sv -----
// Top level of the bidirectional index remap table.
//
//  channel    handshake            payload
//  request    push / full          i_req_type, i_index_a, i_index_b, i_b_valid,
//                                  i_last_of_batch
//  result     empty / pop          o_result_index, o_result_valid, o_status
//  config     i_cfg_we             i_cfg_data (table_size)
//
// After reset both tables are filled with the identity map, one entry per cycle, so full
// stays high until the fill ends. The back end takes one command a cycle, while the result
// queue has room, for a removal entry, a rejected request or a pair that is only staged;
// a query or a remove also waits in B_QRESP or B_RMWR on the registered table read. A
// pair that closes a batch snapshots each staged old index in B_A1_RS, B_A1_RC, B_A1_WT,
// then writes both tables in B_A2_RS, B_A2_WR. Two-entry queues let each side stall alone.
module bidirectional_index_remap_table_core #(
    parameter int TABLE_DEPTH = 1024,
    parameter int STAGE_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [birt_pkg::TSZ_W-1:0]     i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [2:0]                     i_req_type,
    input  logic [birt_pkg::IDX_W-1:0]     i_index_a,
    input  logic [birt_pkg::IDX_W-1:0]     i_index_b,
    input  logic                           i_b_valid,
    input  logic                           i_last_of_batch,
    output logic                           empty,
    input  logic                           pop,
    output logic [birt_pkg::IDX_W-1:0]     o_result_index,
    output logic                           o_result_valid,
    output logic [1:0]                     o_status
);
    import birt_pkg::*;

    t_cmd w_fe_cmd, w_be_cmd;
    t_res w_be_res, w_out_res;
    logic w_fe_push, w_cmdq_full, w_cmdq_empty, w_cmd_pop;
    logic w_res_push, w_resq_full, w_init_done;

    birt_front #(.TABLE_DEPTH(TABLE_DEPTH), .STAGE_DEPTH(STAGE_DEPTH)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_push         (push),
        .o_full         (full),
        .i_req_type     (i_req_type),
        .i_index_a      (i_index_a),
        .i_index_b      (i_index_b),
        .i_b_valid      (i_b_valid),
        .i_last_of_batch(i_last_of_batch),
        .i_init_done    (w_init_done),
        .i_cmd_full     (w_cmdq_full),
        .o_cmd_push     (w_fe_push),
        .o_cmd          (w_fe_cmd)
    );

    birt_fifo #(.WIDTH($bits(t_cmd)), .DEPTH(CMDQ_DEPTH)) u_cmdq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_fe_push),
        .i_data (w_fe_cmd),
        .o_full (w_cmdq_full),
        .i_pop  (w_cmd_pop),
        .o_data (w_be_cmd),
        .o_empty(w_cmdq_empty)
    );

    birt_back #(.TABLE_DEPTH(TABLE_DEPTH), .STAGE_DEPTH(STAGE_DEPTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_be_cmd),
        .i_cmd_empty(w_cmdq_empty),
        .o_cmd_pop  (w_cmd_pop),
        .i_res_full (w_resq_full),
        .o_res_push (w_res_push),
        .o_res      (w_be_res),
        .o_init_done(w_init_done)
    );

    birt_fifo #(.WIDTH($bits(t_res)), .DEPTH(RESQ_DEPTH)) u_resq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_be_res),
        .o_full (w_resq_full),
        .i_pop  (pop),
        .o_data (w_out_res),
        .o_empty(empty)
    );

    assign o_result_index = w_out_res.idx;
    assign o_result_valid = w_out_res.valid;
    assign o_status       = w_out_res.status;
endmodule

// ----- tb/sv/birt_checker.sv -----
// Checker for the remap table: tracks both maps, predicts every result and compares it.
module birt_checker #(
    parameter int TABLE_N = 1024,
    parameter int STAGE_N = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [birt_pkg::TSZ_W-1:0] i_cfg_data,
    input  logic                       i_push,
    input  logic                       i_full,
    input  logic [2:0]                 i_req_type,
    input  logic [birt_pkg::IDX_W-1:0] i_index_a,
    input  logic [birt_pkg::IDX_W-1:0] i_index_b,
    input  logic                       i_b_valid,
    input  logic                       i_last_of_batch,
    input  logic                       i_empty,
    input  logic                       i_pop,
    input  logic [birt_pkg::IDX_W-1:0] i_result_index,
    input  logic                       i_result_valid,
    input  logic [1:0]                 i_status,
    output int                         o_errors,
    output int                         o_pending
);
    import birt_pkg::*;

    logic [TSZ_W-1:0] size_reg;
    logic [IDX_W-1:0] fwd_idx  [TABLE_N];
    logic             fwd_ok   [TABLE_N];
    logic [IDX_W-1:0] back_idx [TABLE_N];
    logic             back_ok  [TABLE_N];
    logic [IDX_W-1:0] stage_cur [STAGE_N];
    logic [IDX_W-1:0] stage_nxt [STAGE_N];
    logic             stage_nok [STAGE_N];
    int               stage_count;
    t_res             due_results[$];
    t_res             got;
    t_res             want;
    int               mismatches = 0;

    task automatic reset_tables();
        for (int i = 0; i < TABLE_N; i++) begin
            fwd_idx[i]  = IDX_W'(i);
            back_idx[i] = IDX_W'(i);
            fwd_ok[i]   = 1'b1;
            back_ok[i]  = 1'b1;
        end
        stage_count = 0;
        size_reg    = TSZ_RESET;
    endtask

    // Every old index is looked up before any table is written.
    task automatic apply_staged();
        logic [IDX_W-1:0] snap_old [STAGE_N];
        logic             snap_ok  [STAGE_N];
        for (int i = 0; i < stage_count; i++) begin
            snap_old[i] = back_idx[stage_cur[i]];
            snap_ok[i]  = back_ok[stage_cur[i]];
        end
        for (int i = 0; i < stage_count; i++) begin
            if (snap_ok[i]) begin
                fwd_idx[snap_old[i]] = stage_nok[i] ? stage_nxt[i] : '0;
                fwd_ok[snap_old[i]]  = stage_nok[i];
            end
            if (stage_nok[i]) begin
                back_idx[stage_nxt[i]] = snap_ok[i] ? snap_old[i] : '0;
                back_ok[stage_nxt[i]]  = snap_ok[i];
            end
        end
        stage_count = 0;
    endtask

    task automatic predict_remap(input logic [2:0] kind, input logic [IDX_W-1:0] a,
                                 input logic [IDX_W-1:0] b, input logic bv,
                                 input logic closes, output t_res r);
        int lim;
        lim = (int'(size_reg) < TABLE_N) ? int'(size_reg) : TABLE_N;
        r = '0;
        case (kind)
            REQ_CUR_FROM_OLD, REQ_OLD_FROM_CUR: begin
                if (a >= lim) begin
                    r.status = ST_RANGE;
                end else if (kind == REQ_CUR_FROM_OLD) begin
                    r.valid = fwd_ok[a];
                    r.idx   = fwd_ok[a] ? fwd_idx[a] : '0;
                end else begin
                    r.valid = back_ok[a];
                    r.idx   = back_ok[a] ? back_idx[a] : '0;
                end
            end
            REQ_REMOVE: begin
                if (a >= lim) begin
                    r.status = ST_RANGE;
                end else begin
                    if (back_ok[a]) begin
                        fwd_ok[back_idx[a]]  = 1'b0;
                        fwd_idx[back_idx[a]] = '0;
                    end
                    back_ok[a]  = 1'b0;
                    back_idx[a] = '0;
                end
            end
            REQ_MOVE_PAIR: begin
                if (a >= lim || (bv && b >= lim)) begin
                    r.status = ST_RANGE;
                end else if (stage_count >= STAGE_N) begin
                    r.status = ST_FULL;
                end else begin
                    stage_cur[stage_count] = a;
                    stage_nxt[stage_count] = bv ? b : '0;
                    stage_nok[stage_count] = bv;
                    stage_count++;
                end
                // The batch is applied even when this closing pair was rejected.
                if (closes) apply_staged();
            end
            REQ_REMOVAL: begin
                if (a >= lim) begin
                    r.status = ST_RANGE;
                end else begin
                    back_ok[a]  = 1'b0;
                    back_idx[a] = '0;
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_tables();
            due_results.delete();
            o_pending <= 0;
        end else begin
            if (i_pop && !i_empty) begin
                got.idx    = i_result_index;
                got.valid  = i_result_valid;
                got.status = i_status;
                if (due_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result transaction: idx %0d valid %0b status %0d",
                                 got.idx, got.valid, got.status);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    if (got.idx !== want.idx || got.valid !== want.valid
                            || got.status !== want.status) begin
                        // Values are given as index/valid/status.
                        if (mismatches < 10)
                            $display("mismatch: expected %0d/%0b/%0d, got %0d/%0b/%0d",
                                     want.idx, want.valid, want.status,
                                     got.idx, got.valid, got.status);
                        mismatches++;
                    end
                end
            end
            // A request accepted at this edge still sees the size held before it.
            if (i_push && !i_full) begin
                predict_remap(i_req_type, i_index_a, i_index_b, i_b_valid,
                              i_last_of_batch, want);
                due_results.push_back(want);
            end
            if (i_cfg_we) size_reg = i_cfg_data;
            o_pending <= due_results.size();
            o_errors  <= mismatches;
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for the remap table: clock, reset, stimulus, result stalls and verdict.
module tb;
    import birt_pkg::*;

    localparam int TABLE_N = 1024;
    localparam int STAGE_N = 64;
    localparam int SETTLE_CYCLES = 16;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [TSZ_W-1:0] cfg_data = '0;
    logic             push = 1'b0;
    logic             full;
    logic [2:0]       req_type = '0;
    logic [IDX_W-1:0] index_a = '0;
    logic [IDX_W-1:0] index_b = '0;
    logic             b_valid = 1'b0;
    logic             last_of_batch = 1'b0;
    logic             empty;
    logic             pop = 1'b0;
    logic [IDX_W-1:0] result_index;
    logic             result_valid;
    logic [1:0]       status;
    int               n_errors;
    int               n_pending;

    int burst_left = 0;
    int n_sent = 0;
    int cur_limit = TABLE_N;
    int pop_pct = 100;
    int pop_epoch = 0;

    always #10 i_clk = ~i_clk;

    bidirectional_index_remap_table_core #(
        .TABLE_DEPTH(TABLE_N),
        .STAGE_DEPTH(STAGE_N)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_data(cfg_data),
        .push(push),
        .full(full),
        .i_req_type(req_type),
        .i_index_a(index_a),
        .i_index_b(index_b),
        .i_b_valid(b_valid),
        .i_last_of_batch(last_of_batch),
        .empty(empty),
        .pop(pop),
        .o_result_index(result_index),
        .o_result_valid(result_valid),
        .o_status(status)
    );

    birt_checker #(
        .TABLE_N(TABLE_N),
        .STAGE_N(STAGE_N)
    ) i_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_data(cfg_data),
        .i_push(push),
        .i_full(full),
        .i_req_type(req_type),
        .i_index_a(index_a),
        .i_index_b(index_b),
        .i_b_valid(b_valid),
        .i_last_of_batch(last_of_batch),
        .i_empty(empty),
        .i_pop(pop),
        .i_result_index(result_index),
        .i_result_valid(result_valid),
        .i_status(status),
        .o_errors(n_errors),
        .o_pending(n_pending)
    );

    // The receiver changes its appetite at the end of each random epoch, from never stalling
    // to stalling nearly all the time.
    always @(posedge i_clk) begin
        if (pop_epoch == 0) begin
            pop_epoch <= $urandom_range(32, 256);
            case ($urandom_range(0, 3))
                0: pop_pct <= 100;
                1: pop_pct <= 70;
                2: pop_pct <= 30;
                default: pop_pct <= 8;
            endcase
        end else begin
            pop_epoch <= pop_epoch - 1;
        end
        pop <= ($urandom_range(0, 99) < pop_pct);
    end

    function automatic logic [IDX_W-1:0] pick_index();
        if (cur_limit < TABLE_N && $urandom_range(0, 19) == 0)
            return IDX_W'(cur_limit);
        if (cur_limit == 0 || $urandom_range(0, 9) == 0)
            return IDX_W'($urandom_range(0, TABLE_N - 1));
        return IDX_W'($urandom_range(0, cur_limit - 1));
    endfunction

    // Holds the request until it is accepted; push stays high within a burst.
    task automatic send_req(input logic [2:0] kind, input logic [IDX_W-1:0] a,
                            input logic [IDX_W-1:0] b, input logic bv, input logic closes);
        int gap;
        push          <= 1'b1;
        req_type      <= kind;
        index_a       <= a;
        index_b       <= b;
        b_valid       <= bv;
        last_of_batch <= closes;
        do @(posedge i_clk); while (full);
        n_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(0, 15);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_batch(input int size);
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic             bv;
        logic             closes;
        for (int j = 0; j < size; j++) begin
            a      = pick_index();
            b      = pick_index();
            bv     = ($urandom_range(0, 7) != 0);
            // Now and then a batch is left open and carries over into later requests.
            closes = (j == size - 1) && ($urandom_range(0, 9) != 0);
            send_req(REQ_MOVE_PAIR, a, b, bv, closes);
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input int v);
        cfg_we   <= 1'b1;
        cfg_data <= TSZ_W'(v);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cur_limit = (v < TABLE_N) ? v : TABLE_N;
    endtask

    task automatic run_traffic(input int n, input bit overfill);
        int target;
        int pick;
        target = n_sent + n;
        if (overfill) send_batch(STAGE_N + 2);
        while (n_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_batch(($urandom_range(0, 59) == 0) ? $urandom_range(STAGE_N, STAGE_N + 3)
                                                        : $urandom_range(1, 6));
            end else if (pick < 60) begin
                send_req(REQ_CUR_FROM_OLD, pick_index(), pick_index(),
                         1'($urandom), 1'($urandom));
            end else if (pick < 75) begin
                send_req(REQ_OLD_FROM_CUR, pick_index(), pick_index(),
                         1'($urandom), 1'($urandom));
            end else if (pick < 84) begin
                send_req(REQ_REMOVE, pick_index(), pick_index(), 1'($urandom), 1'($urandom));
            end else if (pick < 94) begin
                send_req(REQ_REMOVAL, pick_index(), pick_index(), 1'($urandom), 1'($urandom));
            end else begin
                send_req(3'(REQ_REMOVAL + $urandom_range(1, 3)), pick_index(), pick_index(),
                         1'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset table size.
        send_req(REQ_CUR_FROM_OLD, '0, '0, 1'b0, 1'b0);
        send_req(REQ_CUR_FROM_OLD, '1, '1, 1'b1, 1'b1);
        send_req(REQ_OLD_FROM_CUR, '0, '0, 1'b0, 1'b0);
        send_req(REQ_OLD_FROM_CUR, '1, '1, 1'b1, 1'b0);
        send_req(REQ_REMOVE, 10'd5, '0, 1'b0, 1'b0);
        send_req(REQ_CUR_FROM_OLD, 10'd5, '0, 1'b0, 1'b0);
        send_req(REQ_OLD_FROM_CUR, 10'd5, '0, 1'b0, 1'b0);
        // A remove after a removal entry finds no valid old index.
        send_req(REQ_REMOVAL, 10'd7, '0, 1'b0, 1'b0);
        send_req(REQ_REMOVE, 10'd7, '0, 1'b0, 1'b0);
        send_req(REQ_CUR_FROM_OLD, 10'd7, '0, 1'b0, 1'b0);
        // A swap, a move from an invalidated entry and a vanished endpoint in one batch.
        send_req(REQ_MOVE_PAIR, 10'd10, 10'd20, 1'b1, 1'b0);
        send_req(REQ_MOVE_PAIR, 10'd20, 10'd10, 1'b1, 1'b0);
        send_req(REQ_MOVE_PAIR, 10'd7, 10'd30, 1'b1, 1'b0);
        send_req(REQ_MOVE_PAIR, 10'd40, '0, 1'b0, 1'b1);
        send_req(REQ_CUR_FROM_OLD, 10'd10, '0, 1'b0, 1'b0);
        send_req(REQ_CUR_FROM_OLD, 10'd20, '0, 1'b0, 1'b0);
        send_req(REQ_OLD_FROM_CUR, 10'd10, '0, 1'b0, 1'b0);
        send_req(REQ_OLD_FROM_CUR, 10'd30, '0, 1'b0, 1'b0);
        send_req(REQ_CUR_FROM_OLD, 10'd40, '0, 1'b0, 1'b0);
        send_req(REQ_OLD_FROM_CUR, 10'd40, '0, 1'b0, 1'b0);
        send_req(3'(REQ_REMOVAL + 1), '1, '1, 1'b1, 1'b1);
        send_req(3'(REQ_REMOVAL + 2), '1, '1, 1'b1, 1'b1);
        send_req(3'(REQ_REMOVAL + 3), '1, '1, 1'b1, 1'b1);
        send_req(REQ_MOVE_PAIR, '1, '1, 1'b1, 1'b1);
        send_req(REQ_MOVE_PAIR, '1, '1, 1'b0, 1'b1);
        wait_idle();

        write_size(1);
        run_traffic(80, 1'b0);
        wait_idle();
        write_size(TABLE_N);
        run_traffic(300, 1'b1);
        wait_idle();
        write_size(2);
        run_traffic(80, 1'b0);
        wait_idle();
        write_size(0);
        run_traffic(40, 1'b0);
        wait_idle();
        write_size((1 << TSZ_W) - 1);
        run_traffic(200, 1'b0);
        wait_idle();
        write_size($urandom_range(3, TABLE_N - 1));
        run_traffic(300, 1'b0);
        wait_idle();
        write_size(TABLE_N);
        run_traffic(230, 1'b0);
        wait_idle();

        if (n_errors == 0 && n_pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
